// File: design/load_balance_transfer_planner_core_macros.svh
// assertion helpers shared by the planner
`ifndef LOAD_BALANCE_TRANSFER_PLANNER_CORE_MACROS_SVH
`define LOAD_BALANCE_TRANSFER_PLANNER_CORE_MACROS_SVH

// same-cycle implication on the planner clock
`define LBTP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the planner clock
`define LBTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lbtp_pkg.sv
package lbtp_pkg;

    localparam int MAX_WORKERS_DEF = 8;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int GAIN_BITS       = 28;
    localparam int ACT_BITS        = 4;
    localparam int OWN_BITS        = 3;
    localparam int SENDER_BITS     = 3;
    localparam int PADDR_BITS      = 3;
    localparam int PDATA_BITS      = 32;

    localparam logic [ACT_BITS-1:0] ACTIVE_RESET = 4'd8;

    localparam logic [0:0] REG_ACTIVE_WORKERS = 1'b0;
    localparam logic [0:0] REG_OWN_WORKER     = 1'b1;

    typedef enum logic [29:0] {
        ST_LOAD   = 30'h0000_0001,
        ST_CLEAR  = 30'h0000_0002,
        ST_RES    = 30'h0000_0004,
        ST_G_ROW  = 30'h0000_0008,
        ST_G_COL  = 30'h0000_0010,
        ST_L_ROW  = 30'h0000_0020,
        ST_L_COL  = 30'h0000_0040,
        ST_L_INC  = 30'h0000_0080,
        ST_R_IJ   = 30'h0000_0100,
        ST_R_IJW  = 30'h0000_0200,
        ST_R_JK   = 30'h0000_0400,
        ST_R_JKW  = 30'h0000_0800,
        ST_R_CMP  = 30'h0000_1000,
        ST_GE1    = 30'h0000_2000,
        ST_GE2    = 30'h0000_4000,
        ST_GE3    = 30'h0000_8000,
        ST_GE4    = 30'h0001_0000,
        ST_GE5    = 30'h0002_0000,
        ST_LT1    = 30'h0004_0000,
        ST_LT2    = 30'h0008_0000,
        ST_LT3    = 30'h0010_0000,
        ST_LT4    = 30'h0020_0000,
        ST_LT5    = 30'h0040_0000,
        ST_LT6    = 30'h0080_0000,
        ST_CHK    = 30'h0100_0000,
        ST_CHKW   = 30'h0200_0000,
        ST_GA_RD  = 30'h0400_0000,
        ST_GA_AC  = 30'h0800_0000,
        ST_E_RD   = 30'h1000_0000,
        ST_E_LD   = 30'h2000_0000
    } state_t;

    typedef struct packed {
        logic load_last;
        logic init_done;
        logic row_last;
        logic col_last;
        logic k_last;
        logic res_i_pos;
        logic res_i_gt1;
        logic g_end;
        logic rj_zero;
        logic l_end;
        logic rdata_pos;
        logic r_done;
        logic x_ge;
        logic chk_end;
        logic ga_end;
        logic out_free;
        logic e_last;
    } dp_status_t;

endpackage

// File: design/load_balance_transfer_planner_core.sv
// load balance transfer planner
// input channel s_*: one point count word per worker, in worker order; n words
// (n = active_workers clamped to 2..MAX_WORKERS) make one load, one per cycle.
// result channel m_*: after the last count, n*n words, one per matrix entry,
// row by row, each with the own worker's net gain; last_entry marks the end.
// after the last count the planner runs in order: a matrix clearing sweep (the
// average divider runs under it), the residuals, the greedy pass, the
// leftover distribution, then the reroute sequencer over each (i,j) pair and
// its middleman steps, the own worker's gain sum, then the emitted words.
// s_ready is high only while loading; the final word may still wait in the
// output register while the next load is taken.
// when m_ready is low the output register holds and the emitter stalls.
// reset clears the load position and the handshakes; active_workers returns
// to 8 and own_worker to 0. config writes go over the apb port while idle, a rule
// for the user that the block does not enforce; writing active_workers drops a partial load.
module load_balance_transfer_planner_core #(
    parameter int MAX_WORKERS = lbtp_pkg::MAX_WORKERS_DEF,
    parameter int COUNT_BITS  = lbtp_pkg::COUNT_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lbtp_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [lbtp_pkg::PDATA_BITS-1:0]       pwdata,
    output logic [lbtp_pkg::PDATA_BITS-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [COUNT_BITS-1:0]                 s_point_count,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lbtp_pkg::SENDER_BITS-1:0]      m_sender,
    output logic [lbtp_pkg::SENDER_BITS-1:0]      m_receiver,
    output logic [COUNT_BITS-1:0]                 m_amount,
    output logic signed [lbtp_pkg::GAIN_BITS-1:0] m_net_gain,
    output logic                                  m_last_entry
);

    `include "load_balance_transfer_planner_core_macros.svh"

    localparam int NW = $clog2(MAX_WORKERS + 1);
    localparam int AB = lbtp_pkg::ACT_BITS;
    localparam int OB = lbtp_pkg::OWN_BITS;
    localparam int DB = lbtp_pkg::PDATA_BITS;

    logic [AB-1:0] active_reg, active_next;
    logic [OB-1:0] own_reg, own_next;
    logic          cfg_wr, cfg_clr, own_ok;
    logic [NW-1:0] n_eff;

    lbtp_pkg::state_t     cmd;
    lbtp_pkg::dp_status_t status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_clr = cfg_wr && (paddr[2] == lbtp_pkg::REG_ACTIVE_WORKERS);

    always_comb begin
        active_next = active_reg;
        own_next    = own_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                lbtp_pkg::REG_ACTIVE_WORKERS: active_next = pwdata[AB-1:0];
                lbtp_pkg::REG_OWN_WORKER:     own_next    = pwdata[OB-1:0];
                default:                      own_next    = own_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= lbtp_pkg::ACTIVE_RESET;
            own_reg    <= '0;
        end else begin
            active_reg <= active_next;
            own_reg    <= own_next;
        end
    end

    always_comb begin
        unique case (paddr[2])
            lbtp_pkg::REG_ACTIVE_WORKERS: prdata = DB'(active_reg);
            lbtp_pkg::REG_OWN_WORKER:     prdata = DB'(own_reg);
            default:                      prdata = '0;
        endcase
    end

    always_comb begin
        priority if (active_reg < AB'(2)) begin
            n_eff = NW'(2);
        end else if (active_reg > AB'(MAX_WORKERS)) begin
            n_eff = NW'(MAX_WORKERS);
        end else begin
            n_eff = NW'(active_reg);
        end
    end

    assign own_ok = (AB'(own_reg) < AB'(n_eff));

    lbtp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .own_ok  (own_ok),
        .status  (status),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    lbtp_datapath #(
        .MAX_WORKERS (MAX_WORKERS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .n_eff         (n_eff),
        .own           (own_reg),
        .own_ok        (own_ok),
        .cfg_clr       (cfg_clr),
        .s_valid       (s_valid),
        .s_point_count (s_point_count),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_sender      (m_sender),
        .m_receiver    (m_receiver),
        .m_amount      (m_amount),
        .m_net_gain    (m_net_gain),
        .m_last_entry  (m_last_entry),
        .status        (status)
    );

    `LBTP_ASSERT_SAME(a_load_waits_on_last, m_valid && s_ready, m_last_entry,
        "pending word during load is not the final entry")
    `LBTP_ASSERT_NEXT(a_no_load_mid_plan, m_valid && m_ready && !m_last_entry, !s_ready,
        "load reopened before the plan was emitted")
    `LBTP_ASSERT_NEXT(a_plan_closes_load, s_valid && s_ready && status.load_last, !s_ready,
        "load still open after the closing count")

endmodule

// File: design/lbtp_ram.sv
module lbtp_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/lbtp_ctrl.sv
module lbtp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   own_ok,
    input  lbtp_pkg::dp_status_t   status,
    output lbtp_pkg::state_t       cmd,
    output logic                   s_ready
);

    lbtp_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lbtp_pkg::ST_LOAD: begin
                if (status.load_last) state_next = lbtp_pkg::ST_CLEAR;
            end
            lbtp_pkg::ST_CLEAR: begin
                if (status.init_done) state_next = lbtp_pkg::ST_RES;
            end
            lbtp_pkg::ST_RES: begin
                if (status.row_last) state_next = lbtp_pkg::ST_G_ROW;
            end
            lbtp_pkg::ST_G_ROW: begin
                priority if (status.res_i_pos) state_next = lbtp_pkg::ST_G_COL;
                else if (status.row_last)      state_next = lbtp_pkg::ST_L_ROW;
            end
            lbtp_pkg::ST_G_COL: begin
                if (status.g_end) begin
                    state_next = status.row_last ? lbtp_pkg::ST_L_ROW : lbtp_pkg::ST_G_ROW;
                end
            end
            lbtp_pkg::ST_L_ROW: begin
                priority if (status.res_i_gt1) state_next = lbtp_pkg::ST_L_COL;
                else if (status.row_last)      state_next = lbtp_pkg::ST_R_IJ;
            end
            lbtp_pkg::ST_L_COL: begin
                priority if (status.rj_zero) begin
                    state_next = lbtp_pkg::ST_L_INC;
                end else if (status.l_end) begin
                    state_next = status.row_last ? lbtp_pkg::ST_R_IJ : lbtp_pkg::ST_L_ROW;
                end
            end
            lbtp_pkg::ST_L_INC: begin
                if (status.l_end) begin
                    state_next = status.row_last ? lbtp_pkg::ST_R_IJ : lbtp_pkg::ST_L_ROW;
                end else begin
                    state_next = lbtp_pkg::ST_L_COL;
                end
            end
            lbtp_pkg::ST_R_IJ:  state_next = lbtp_pkg::ST_R_IJW;
            lbtp_pkg::ST_R_IJW: begin
                priority if (status.rdata_pos) state_next = lbtp_pkg::ST_R_JK;
                else if (status.r_done)        state_next = lbtp_pkg::ST_GA_RD;
                else                           state_next = lbtp_pkg::ST_R_IJ;
            end
            lbtp_pkg::ST_R_JK:  state_next = lbtp_pkg::ST_R_JKW;
            lbtp_pkg::ST_R_JKW: begin
                state_next = status.rdata_pos ? lbtp_pkg::ST_R_CMP : lbtp_pkg::ST_CHK;
            end
            lbtp_pkg::ST_R_CMP: begin
                state_next = status.x_ge ? lbtp_pkg::ST_GE1 : lbtp_pkg::ST_LT1;
            end
            lbtp_pkg::ST_GE1: state_next = lbtp_pkg::ST_GE2;
            lbtp_pkg::ST_GE2: state_next = lbtp_pkg::ST_GE3;
            lbtp_pkg::ST_GE3: state_next = lbtp_pkg::ST_GE4;
            lbtp_pkg::ST_GE4: state_next = lbtp_pkg::ST_GE5;
            lbtp_pkg::ST_GE5: state_next = lbtp_pkg::ST_CHK;
            lbtp_pkg::ST_LT1: state_next = lbtp_pkg::ST_LT2;
            lbtp_pkg::ST_LT2: state_next = lbtp_pkg::ST_LT3;
            lbtp_pkg::ST_LT3: state_next = lbtp_pkg::ST_LT4;
            lbtp_pkg::ST_LT4: state_next = lbtp_pkg::ST_LT5;
            lbtp_pkg::ST_LT5: state_next = lbtp_pkg::ST_LT6;
            lbtp_pkg::ST_LT6: state_next = lbtp_pkg::ST_CHK;
            lbtp_pkg::ST_CHK: state_next = lbtp_pkg::ST_CHKW;
            lbtp_pkg::ST_CHKW: begin
                priority if (!status.chk_end) state_next = lbtp_pkg::ST_R_JK;
                else if (status.r_done)       state_next = lbtp_pkg::ST_GA_RD;
                else                          state_next = lbtp_pkg::ST_R_IJ;
            end
            lbtp_pkg::ST_GA_RD: begin
                state_next = own_ok ? lbtp_pkg::ST_GA_AC : lbtp_pkg::ST_E_RD;
            end
            lbtp_pkg::ST_GA_AC: begin
                state_next = status.ga_end ? lbtp_pkg::ST_E_RD : lbtp_pkg::ST_GA_RD;
            end
            lbtp_pkg::ST_E_RD: begin
                if (status.out_free) state_next = lbtp_pkg::ST_E_LD;
            end
            lbtp_pkg::ST_E_LD: begin
                state_next = status.e_last ? lbtp_pkg::ST_LOAD : lbtp_pkg::ST_E_RD;
            end
            default: state_next = lbtp_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lbtp_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    assign cmd     = state_reg;
    assign s_ready = (state_reg == lbtp_pkg::ST_LOAD);

endmodule

// File: design/lbtp_datapath.sv
module lbtp_datapath #(
    parameter int MAX_WORKERS = lbtp_pkg::MAX_WORKERS_DEF,
    parameter int COUNT_BITS  = lbtp_pkg::COUNT_BITS_DEF,
    localparam int NW = $clog2(MAX_WORKERS + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lbtp_pkg::state_t                    cmd,
    input  logic [NW-1:0]                       n_eff,
    input  logic [lbtp_pkg::OWN_BITS-1:0]       own,
    input  logic                                own_ok,
    input  logic                                cfg_clr,
    input  logic                                s_valid,
    input  logic [COUNT_BITS-1:0]               s_point_count,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [lbtp_pkg::SENDER_BITS-1:0]    m_sender,
    output logic [lbtp_pkg::SENDER_BITS-1:0]    m_receiver,
    output logic [COUNT_BITS-1:0]               m_amount,
    output logic signed [lbtp_pkg::GAIN_BITS-1:0] m_net_gain,
    output logic                                m_last_entry,
    output lbtp_pkg::dp_status_t                status
);

    localparam int IW    = $clog2(MAX_WORKERS);
    localparam int SW    = COUNT_BITS + 3;
    localparam int RW    = COUNT_BITS + 2;
    localparam int MW    = COUNT_BITS + 4;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int GB    = lbtp_pkg::GAIN_BITS;
    localparam int SB    = lbtp_pkg::SENDER_BITS;
    localparam int DCW   = $clog2(SW + 1);

    // load and divide
    logic [IW-1:0]          idx_reg, idx_next;
    logic [SW-1:0]          sum_reg, sum_next;
    logic [SW-1:0]          dq_reg, dq_next;
    logic [NW-1:0]          rem_reg, rem_next;
    logic [DCW-1:0]         dcnt_reg, dcnt_next;
    logic                   div_done_reg, div_done_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic                   clr_done_reg, clr_done_next;
    logic [COUNT_BITS-1:0]  cnt_reg [MAX_WORKERS];
    logic [COUNT_BITS-1:0]  cnt_next [MAX_WORKERS];
    // planning
    logic signed [RW-1:0]   res_reg [MAX_WORKERS];
    logic signed [RW-1:0]   res_next [MAX_WORKERS];
    logic [IW-1:0]          i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic signed [RW-1:0]   ri_reg, ri_next;
    logic signed [MW-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [GB-1:0]   gain_reg, gain_next;
    logic                   phase_reg, phase_next;
    // word out
    logic                   m_valid_reg, m_valid_next;
    logic [SB-1:0]          snd_reg, snd_next, rcv_reg, rcv_next;
    logic [COUNT_BITS-1:0]  amt_reg, amt_next;
    logic signed [GB-1:0]   gout_reg, gout_next;
    logic                   last_reg, last_next;

    logic                   wr_en, rd_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [MW-1:0]          wr_data, rd_data;

    logic [NW-1:0]          n_m1;
    logic                   s_acc, row_last, col_last, k_last, load_last, init_done;
    logic signed [RW-1:0]   res_i, rj;
    logic signed [MW-1:0]   rdata_s;
    logic                   rj_neg, rj_covers, rj_zero, g_end, l_end, r_done, out_free;
    logic [NW:0]            rem_sh;
    logic                   q_bit;
    logic [IW-1:0]          own_w;
    logic [AW-1:0]          a_ij, a_jk, a_ik;

    assign n_m1      = n_eff - NW'(1);
    assign s_acc     = s_valid && (cmd == lbtp_pkg::ST_LOAD);
    assign row_last  = (NW'(i_reg) == n_m1);
    assign col_last  = (NW'(j_reg) == n_m1);
    assign k_last    = (NW'(k_reg) == n_m1);
    assign load_last = s_acc && (NW'(idx_reg) == n_m1);
    assign init_done = clr_done_reg && div_done_reg;
    assign res_i     = res_reg[i_reg];
    assign rj        = (j_reg == i_reg) ? ri_reg : res_reg[j_reg];
    assign rdata_s   = $signed(rd_data);
    assign rj_neg    = (rj < 0);
    assign rj_covers = (-rj >= ri_reg);
    assign rj_zero   = (rj == '0);
    assign g_end     = (rj_neg && rj_covers) || col_last;
    assign l_end     = (ri_reg == RW'(1)) || col_last;
    assign r_done    = row_last && col_last;
    assign out_free  = !m_valid_reg || m_ready;
    assign rem_sh    = {rem_reg, dq_reg[SW-1]};
    assign q_bit     = (rem_sh >= {1'b0, n_eff});
    assign own_w     = IW'(own);
    assign a_ij      = {i_reg, j_reg};
    assign a_jk      = {j_reg, k_reg};
    assign a_ik      = {i_reg, k_reg};

    always_comb begin
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        div_done_next = div_done_reg;
        clr_addr_next = clr_addr_reg;
        clr_done_next = clr_done_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        ri_next       = ri_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        gain_next     = gain_reg;
        phase_next    = phase_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        snd_next      = snd_reg;
        rcv_next      = rcv_reg;
        amt_next      = amt_reg;
        gout_next     = gout_reg;
        last_next     = last_reg;
        wr_en         = 1'b0;
        wr_addr       = a_ij;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = a_ij;

        unique case (cmd)
            lbtp_pkg::ST_LOAD: begin
                if (s_acc) begin
                    cnt_next[idx_reg] = s_point_count;
                    if (load_last) begin
                        idx_next      = '0;
                        sum_next      = '0;
                        dq_next       = sum_reg + SW'(s_point_count);
                        rem_next      = '0;
                        dcnt_next     = '0;
                        div_done_next = 1'b0;
                        clr_addr_next = '0;
                        clr_done_next = 1'b0;
                    end else begin
                        idx_next = idx_reg + IW'(1);
                        sum_next = sum_reg + SW'(s_point_count);
                    end
                end
            end
            lbtp_pkg::ST_CLEAR: begin
                if (!clr_done_reg) begin
                    wr_en         = 1'b1;
                    wr_addr       = clr_addr_reg;
                    clr_addr_next = clr_addr_reg + AW'(1);
                    if (clr_addr_reg == {AW{1'b1}}) clr_done_next = 1'b1;
                end
                // one quotient bit per cycle
                if (!div_done_reg) begin
                    rem_next  = q_bit ? NW'(rem_sh - {1'b0, n_eff}) : NW'(rem_sh);
                    dq_next   = {dq_reg[SW-2:0], q_bit};
                    dcnt_next = dcnt_reg + DCW'(1);
                    if (dcnt_reg == DCW'(SW - 1)) div_done_next = 1'b1;
                end
                if (init_done) i_next = '0;
            end
            lbtp_pkg::ST_RES: begin
                res_next[i_reg] = $signed(RW'(cnt_reg[i_reg])) - $signed(RW'(dq_reg));
                i_next = row_last ? '0 : i_reg + IW'(1);
            end
            lbtp_pkg::ST_G_ROW: begin
                priority if (res_i > 0) begin
                    ri_next = res_i;
                    j_next  = '0;
                end else if (row_last) begin
                    i_next = '0;
                end else begin
                    i_next = i_reg + IW'(1);
                end
            end
            lbtp_pkg::ST_G_COL: begin
                priority if (rj_neg && rj_covers) begin
                    wr_en            = 1'b1;
                    wr_data          = MW'(ri_reg);
                    res_next[j_reg]  = rj + ri_reg;
                    ri_next          = '0;
                    res_next[i_reg]  = '0;
                end else if (rj_neg) begin
                    wr_en           = 1'b1;
                    wr_data         = MW'(-rj);
                    ri_next         = ri_reg + rj;
                    res_next[j_reg] = '0;
                    if (col_last) res_next[i_reg] = ri_reg + rj;
                end else begin
                    if (col_last) res_next[i_reg] = ri_reg;
                end
                if (g_end) begin
                    i_next = row_last ? '0 : i_reg + IW'(1);
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end
            lbtp_pkg::ST_L_ROW: begin
                priority if (res_i > RW'(1)) begin
                    ri_next = res_i;
                    j_next  = '0;
                end else if (row_last) begin
                    i_next = '0;
                    j_next = '0;
                end else begin
                    i_next = i_reg + IW'(1);
                end
            end
            lbtp_pkg::ST_L_COL, lbtp_pkg::ST_L_INC: begin
                if ((cmd == lbtp_pkg::ST_L_COL) && rj_zero) begin
                    res_next[j_reg] = RW'(1);
                    ri_next         = ri_reg - RW'(1);
                    rd_en           = 1'b1;
                end else begin
                    if (cmd == lbtp_pkg::ST_L_INC) begin
                        wr_en   = 1'b1;
                        wr_data = rd_data + MW'(1);
                    end
                    if (l_end) begin
                        res_next[i_reg] = ri_reg;
                        if (row_last) begin
                            i_next = '0;
                            j_next = '0;
                        end else begin
                            i_next = i_reg + IW'(1);
                        end
                    end else begin
                        j_next = j_reg + IW'(1);
                    end
                end
            end
            lbtp_pkg::ST_R_IJ, lbtp_pkg::ST_CHK: begin
                rd_en = 1'b1;
            end
            lbtp_pkg::ST_R_IJW, lbtp_pkg::ST_CHKW: begin
                if ((cmd == lbtp_pkg::ST_R_IJW) && (rdata_s > 0)) begin
                    k_next = '0;
                end else if ((cmd == lbtp_pkg::ST_CHKW) && !(rdata_s == '0 || k_last)) begin
                    k_next = k_reg + IW'(1);
                end else if (col_last) begin
                    j_next = '0;
                    if (row_last) begin
                        i_next     = '0;
                        phase_next = 1'b0;
                        gain_next  = '0;
                    end else begin
                        i_next = i_reg + IW'(1);
                    end
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end
            lbtp_pkg::ST_R_JK, lbtp_pkg::ST_LT3, lbtp_pkg::ST_GE1, lbtp_pkg::ST_LT6: begin
                rd_addr = a_jk;
                rd_en   = (cmd == lbtp_pkg::ST_R_JK) || (cmd == lbtp_pkg::ST_LT3);
                wr_addr = a_jk;
                wr_en   = (cmd == lbtp_pkg::ST_GE1) || (cmd == lbtp_pkg::ST_LT6);
                wr_data = (cmd == lbtp_pkg::ST_GE1) ? MW'(x_reg - y_reg) : '0;
            end
            lbtp_pkg::ST_R_JKW: begin
                x_next = rdata_s;
                rd_en  = (rdata_s > 0);
            end
            lbtp_pkg::ST_R_CMP: begin
                y_next = rdata_s;
            end
            lbtp_pkg::ST_GE2: begin
                rd_en = 1'b1;
            end
            lbtp_pkg::ST_GE3, lbtp_pkg::ST_LT1: begin
                if (cmd == lbtp_pkg::ST_GE3) y_next = rdata_s;
                rd_en   = 1'b1;
                rd_addr = a_ik;
            end
            lbtp_pkg::ST_GE4, lbtp_pkg::ST_LT2: begin
                wr_en   = 1'b1;
                wr_addr = a_ik;
                wr_data = (cmd == lbtp_pkg::ST_GE4) ? MW'(rdata_s + y_reg)
                                                    : MW'(rdata_s + x_reg);
            end
            lbtp_pkg::ST_GE5: begin
                wr_en = 1'b1;
            end
            lbtp_pkg::ST_LT4: begin
                x_next = rdata_s;
                rd_en  = 1'b1;
            end
            lbtp_pkg::ST_LT5: begin
                wr_en   = 1'b1;
                wr_data = MW'(rdata_s - x_reg);
            end
            lbtp_pkg::ST_GA_RD: begin
                rd_en   = own_ok;
                rd_addr = phase_reg ? {own_w, i_reg} : {i_reg, own_w};
            end
            lbtp_pkg::ST_GA_AC: begin
                if (phase_reg) begin
                    gain_next  = gain_reg - GB'(rdata_s);
                    phase_next = 1'b0;
                    if (row_last) begin
                        i_next = '0;
                        j_next = '0;
                    end else begin
                        i_next = i_reg + IW'(1);
                    end
                end else begin
                    gain_next  = gain_reg + GB'(rdata_s);
                    phase_next = 1'b1;
                end
            end
            lbtp_pkg::ST_E_RD: begin
                rd_en = out_free;
            end
            lbtp_pkg::ST_E_LD: begin
                m_valid_next = 1'b1;
                snd_next     = SB'(i_reg);
                rcv_next     = SB'(j_reg);
                amt_next     = rd_data[COUNT_BITS-1:0];
                gout_next    = gain_reg;
                last_next    = r_done;
                if (col_last) begin
                    j_next = '0;
                    i_next = i_reg + IW'(1);
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase

        if (cfg_clr) begin
            idx_next = '0;
            sum_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            sum_reg      <= '0;
            div_done_reg <= 1'b1;
            clr_done_reg <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            sum_reg      <= sum_next;
            div_done_reg <= div_done_next;
            clr_done_reg <= clr_done_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        clr_addr_reg <= clr_addr_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        ri_reg       <= ri_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        gain_reg     <= gain_next;
        phase_reg    <= phase_next;
        snd_reg      <= snd_next;
        rcv_reg      <= rcv_next;
        amt_reg      <= amt_next;
        gout_reg     <= gout_next;
        last_reg     <= last_next;
    end

    lbtp_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_matrix (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign status.load_last = load_last;
    assign status.init_done = init_done;
    assign status.row_last  = row_last;
    assign status.col_last  = col_last;
    assign status.k_last    = k_last;
    assign status.res_i_pos = (res_i > 0);
    assign status.res_i_gt1 = (res_i > RW'(1));
    assign status.g_end     = g_end;
    assign status.rj_zero   = rj_zero;
    assign status.l_end     = l_end;
    assign status.rdata_pos = (rdata_s > 0);
    assign status.r_done    = r_done;
    assign status.x_ge      = (x_reg >= rdata_s);
    assign status.chk_end   = (rdata_s == '0) || k_last;
    assign status.ga_end    = phase_reg && row_last;
    assign status.out_free  = out_free;
    assign status.e_last    = r_done;

    assign m_valid      = m_valid_reg;
    assign m_sender     = snd_reg;
    assign m_receiver   = rcv_reg;
    assign m_amount     = amt_reg;
    assign m_net_gain   = gout_reg;
    assign m_last_entry = last_reg;

endmodule
